/* rtl/lru_tile_page_cache_macros.svh */
// assertion macros for the tile page cache
// used by the top level only
`ifndef LRU_TILE_PAGE_CACHE_MACROS_SVH
`define LRU_TILE_PAGE_CACHE_MACROS_SVH
// implication checked on every clock unless in reset
`define LTPC_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// next-cycle implication
`define LTPC_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

/* rtl/ltpc_pkg.sv */
// shared types and constants for the tile page cache
// no dependencies
package ltpc_pkg;
    localparam int PAGES_X_DEF = 8;
    localparam int PAGES_Y_DEF = 8;
    localparam logic [10:0] PAGE_EDGE_RST = 11'd128;

    localparam logic [1:0] REQ_UPLOAD  = 2'd0;
    localparam logic [1:0] REQ_EVICT   = 2'd1;
    localparam logic [1:0] REQ_TOUCH   = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_PLACED   = 3'd1;
    localparam logic [2:0] ST_EVICTED  = 3'd2;
    localparam logic [2:0] ST_EVMISS   = 3'd3;
    localparam logic [2:0] ST_TOUCHED  = 3'd4;
    localparam logic [2:0] ST_TOUCH_OR = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_MIN, S_DECIDE, S_MUL, S_OUT
    } t_state;
endpackage

/* rtl/ltpc_scan.sv */
// scan unit: one page per cycle while i_step is high, tag match and oldest-stamp compare
// no dependencies on ltpc_pkg
module ltpc_scan #(
    parameter int IW = 6
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic          i_used,
    input  logic [35:0]   i_tag,
    input  logic [31:0]   i_stamp,
    input  logic [35:0]   i_key,
    input  logic [IW-1:0] i_idx,
    output logic          o_hit,
    output logic [IW-1:0] o_hit_idx,
    output logic          o_best_v,
    output logic [IW-1:0] o_best_idx
);
    logic [31:0] r_best_stamp;
    // running hit and minimum, first match and first minimum win
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_hit    <= 1'b0;
            o_best_v <= 1'b0;
            o_hit_idx <= '0;
            o_best_idx <= '0;
            r_best_stamp <= '0;
        end else if (i_step && i_used) begin
            if (!o_hit && i_tag == i_key) begin
                o_hit     <= 1'b1;
                o_hit_idx <= i_idx;
            end
            if (!o_best_v || i_stamp < r_best_stamp) begin
                o_best_v     <= 1'b1;
                o_best_idx   <= i_idx;
                r_best_stamp <= i_stamp;
            end
        end
    end
endmodule

/* rtl/lru_tile_page_cache.sv */
// top level of the tile page cache: sequencer, page memories, free stack
// depends on ltpc_pkg, ltpc_scan and lru_tile_page_cache_macros.svh
// Each request is handled one at a time. Upload and evict requests are paced
// by a scan of all page entries, one per cycle, through a single match and
// compare unit, then pass through S_MIN, S_DECIDE, S_MUL and S_OUT, where the
// result beat is registered. A touch request skips the scan and passes
// through S_DECIDE, S_MUL and S_OUT only. A req_type 3 beat is dropped and the
// block is ready again in the next cycle. The block is not ready while a
// request is in flight or its result waits, so a stalled receiver adds its
// stall cycles directly. Tags, stamps and the free stack sit in memories;
// used flags are registers cleared at reset, and free stack entries below a
// low-water mark of the stack depth read as their own index, so no clearing
// pass is needed after reset.
`include "lru_tile_page_cache_macros.svh"
module lru_tile_page_cache #(
    parameter int PAGES_X = ltpc_pkg::PAGES_X_DEF,
    parameter int PAGES_Y = ltpc_pkg::PAGES_Y_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[1:0] tile_x[17:2] tile_y[33:18] tile_level[37:34]
    // page_col[45:38] page_row[53:46] now_ms[85:54], zero fill to 88
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0] out_page_col[5:3] out_page_row[8:6] texel_x[21:9]
    // texel_y[34:22] victim_valid[35] victim_x[51:36] victim_y[67:52]
    // victim_level[71:68]
    output logic [71:0] m_axis_tdata
);
    localparam int NP = PAGES_X * PAGES_Y;
    localparam int IW = (NP > 1) ? $clog2(NP) : 1;
    localparam int CW = $clog2(NP + 1);
    // reciprocal of the row length, exact for every page index
    localparam int RSH = 20;
    localparam int RMUL = ((1 << RSH) + PAGES_X - 1) / PAGES_X;

    ltpc_pkg::t_state r_state, n_state;
    logic [10:0] r_page_edge;
    logic [1:0]  r_req;
    logic [35:0] r_key;
    logic [7:0]  r_pc, r_pr;
    logic [31:0] r_now;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_free_count;
    logic [CW-1:0] r_free_low;
    logic [NP-1:0] r_used;
    logic [35:0] mem_tag [NP];
    logic [31:0] mem_stamp [NP];
    logic [IW-1:0] mem_free [NP];
    logic [35:0] r_rd_tag;
    logic [31:0] r_rd_stamp;
    logic        r_rd_used, r_rd_v;
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_pid;
    logic [2:0]  r_status;
    logic        r_vic_v;
    logic [35:0] r_vic_tag;
    logic [IW-1:0] r_free_mem, r_free_addr;
    logic        r_free_fresh;
    logic [IW-1:0] free_rd_addr, free_top;
    logic [71:0] r_out;
    logic        r_out_v;
    logic        scan_hit, best_v;
    logic [IW-1:0] hit_idx, best_idx;
    logic        accept;
    logic [16:0] touch_pid;
    logic [32:0] div_prod;
    logic [12:0] div_row;
    logic [12:0] r_col, r_row;

    assign s_axis_tready = (r_state == ltpc_pkg::S_IDLE) && !r_out_v;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = r_out;
    assign touch_pid = 17'(r_pr) * 17'(PAGES_X) + 17'(r_pc);

    // top of the free stack, untouched entries hold their own index
    assign free_rd_addr = (r_free_count == '0) ? '0 : IW'(r_free_count - 1'b1);
    assign free_top = r_free_fresh ? r_free_addr : r_free_mem;

    // row of the chosen page by reciprocal multiplication
    assign div_prod = 33'(r_pid) * 33'(RMUL);
    assign div_row = div_prod[32:RSH];

    // scan unit
    ltpc_scan #(.IW(IW)) u_scan (
        .i_clk(i_clk), .i_start(accept), .i_step(r_rd_v),
        .i_used(r_rd_used), .i_tag(r_rd_tag), .i_stamp(r_rd_stamp),
        .i_key(r_key), .i_idx(r_rd_idx), .o_hit(scan_hit), .o_hit_idx(hit_idx),
        .o_best_v(best_v), .o_best_idx(best_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltpc_pkg::S_IDLE: if (accept) begin
                if (s_axis_tdata[1:0] == ltpc_pkg::REQ_TOUCH) n_state = ltpc_pkg::S_DECIDE;
                else if (s_axis_tdata[1:0] != ltpc_pkg::REQ_UNKNOWN)
                    n_state = ltpc_pkg::S_SCAN;
            end
            ltpc_pkg::S_SCAN: if (r_idx == IW'(NP - 1)) n_state = ltpc_pkg::S_MIN;
            ltpc_pkg::S_MIN: n_state = ltpc_pkg::S_DECIDE;
            ltpc_pkg::S_DECIDE: n_state = ltpc_pkg::S_MUL;
            ltpc_pkg::S_MUL: n_state = ltpc_pkg::S_OUT;
            ltpc_pkg::S_OUT: n_state = ltpc_pkg::S_IDLE;
            default: n_state = ltpc_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltpc_pkg::S_IDLE;
            r_page_edge <= ltpc_pkg::PAGE_EDGE_RST;
            r_used <= '0;
            r_free_count <= CW'(NP);
            r_free_low <= CW'(NP);
            r_out_v <= 1'b0;
            r_rd_v <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_page_edge <= i_cfg_wdata;
            r_rd_v <= (r_state == ltpc_pkg::S_SCAN);
            if (r_state == ltpc_pkg::S_OUT) r_out_v <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_out_v <= 1'b0;
            if (accept) r_idx <= '0;
            else if (r_state == ltpc_pkg::S_SCAN) r_idx <= r_idx + 1'b1;
            if (r_state == ltpc_pkg::S_DECIDE) begin
                if (r_req == ltpc_pkg::REQ_EVICT) begin
                    if (scan_hit) begin
                        r_used[hit_idx] <= 1'b0;
                        if (r_free_count < CW'(NP)) r_free_count <= r_free_count + 1'b1;
                    end
                end else if (r_req == ltpc_pkg::REQ_UPLOAD && !scan_hit) begin
                    if (r_free_count == '0) begin
                        r_used[best_v ? best_idx : '0] <= 1'b0;
                        r_free_count <= '0;
                    end else begin
                        r_free_count <= r_free_count - 1'b1;
                        if (r_free_count - 1'b1 < r_free_low)
                            r_free_low <= r_free_count - 1'b1;
                    end
                end
            end
            if (r_state == ltpc_pkg::S_MUL && r_req == ltpc_pkg::REQ_UPLOAD
                && r_status == ltpc_pkg::ST_PLACED) r_used[r_pid] <= 1'b1;
        end
    end

    // payload, memories and free stack
    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            if (r_state == ltpc_pkg::S_DECIDE && r_req == ltpc_pkg::REQ_EVICT
                && scan_hit && r_free_count < CW'(NP))
                mem_free[r_free_count[IW-1:0]] <= hit_idx;
            if (r_state == ltpc_pkg::S_DECIDE && r_req == ltpc_pkg::REQ_UPLOAD
                && !scan_hit && r_free_count == '0)
                mem_free[0] <= best_v ? best_idx : '0;
        end
        if (accept) begin
            r_req <= s_axis_tdata[1:0];
            r_key <= s_axis_tdata[37:2];
            r_pc  <= s_axis_tdata[45:38];
            r_pr  <= s_axis_tdata[53:46];
            r_now <= s_axis_tdata[85:54];
        end
        r_rd_tag     <= mem_tag[r_idx];
        r_rd_stamp   <= mem_stamp[r_idx];
        r_rd_used    <= r_used[r_idx];
        r_rd_idx     <= r_idx;
        r_free_mem   <= mem_free[free_rd_addr];
        r_free_addr  <= free_rd_addr;
        r_free_fresh <= CW'(free_rd_addr) < r_free_low;
        r_vic_tag    <= mem_tag[best_v ? best_idx : '0];
        // decide the page and status
        if (r_state == ltpc_pkg::S_DECIDE) begin
            r_vic_v <= (r_req == ltpc_pkg::REQ_UPLOAD) && !scan_hit
                       && (r_free_count == '0);
            unique case (r_req)
                ltpc_pkg::REQ_TOUCH: begin
                    r_status <= (touch_pid < 17'(NP)) ? ltpc_pkg::ST_TOUCHED
                                                      : ltpc_pkg::ST_TOUCH_OR;
                    if (touch_pid < 17'(NP)) mem_stamp[touch_pid[IW-1:0]] <= r_now;
                end
                ltpc_pkg::REQ_EVICT:
                    r_status <= scan_hit ? ltpc_pkg::ST_EVICTED : ltpc_pkg::ST_EVMISS;
                default: begin
                    if (scan_hit) begin
                        r_status <= ltpc_pkg::ST_HIT;
                        r_pid <= hit_idx;
                    end else begin
                        r_status <= ltpc_pkg::ST_PLACED;
                        if (r_free_count == '0) begin
                            r_pid <= best_v ? best_idx : '0;
                        end else begin
                            r_pid <= free_top;
                        end
                    end
                end
            endcase
        end
        // write the chosen page and split its index into column and row
        if (r_state == ltpc_pkg::S_MUL) begin
            if (r_req == ltpc_pkg::REQ_UPLOAD) begin
                mem_stamp[r_pid] <= r_now;
                if (r_status == ltpc_pkg::ST_PLACED) mem_tag[r_pid] <= r_key;
            end
            r_row <= div_row;
            r_col <= 13'(r_pid) - 13'(div_row * 13'(PAGES_X));
        end
        // result beat: texel offsets and victim for uploads, status only otherwise
        if (r_state == ltpc_pkg::S_OUT) begin
            if (r_req == ltpc_pkg::REQ_UPLOAD) begin
                r_out <= {r_vic_v ? r_vic_tag : 36'd0, r_vic_v,
                          13'(r_row * 13'(r_page_edge)), 13'(r_col * 13'(r_page_edge)),
                          r_row[2:0], r_col[2:0], r_status};
            end else begin
                r_out <= {69'd0, r_status};
            end
        end
    end

    // checks
    `LTPC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, s_axis_tready,
        r_state == ltpc_pkg::S_IDLE && !r_out_v, "ready outside idle")
    `LTPC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1,
        r_free_count <= CW'(NP), "free count beyond page count")
    `LTPC_ASSERT_NXT(a_out_follows, i_clk, i_rst_n, r_state == ltpc_pkg::S_OUT,
        r_out_v, "result lost after sequence end")
endmodule
